>>> hdl/tcsb_pkg.sv
package tcsb_pkg;

   // special bytes
   localparam logic [7:0] CHAR_CR    = 8'd13;
   localparam logic [7:0] CHAR_LF    = 8'd10;
   localparam logic [7:0] CHAR_SPACE = 8'd32;

   // fixed field widths on the streams
   localparam int CHAR_W     = 8;
   localparam int ROW_FIELD_W = 3;
   localparam int COL_FIELD_W = 5;
   localparam int COUNT_W    = 16;

   // controller states
   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_READ,
      ST_SCROLL
   } state_type;

   // controller to datapath
   typedef struct packed {
      logic do_write;
      logic do_read;
      logic load_read;
      logic sweep_en;
      logic sweep_all;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic scroll;
      logic sweep_last;
      logic out_free;
   } status_type;

endpackage

>>> hdl/tcsb_ctrl.sv
module tcsb_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   input  logic                   req_cmd,
   output logic                   req_tready,
   input  tcsb_pkg::status_type   status,
   output tcsb_pkg::cmd_type      cmd
);

   tcsb_pkg::state_type state_ff;
   tcsb_pkg::state_type state_in;
   logic                accept;

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= tcsb_pkg::ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state and commands
   always_comb begin
      state_in      = state_ff;
      req_tready    = 1'b0;
      accept        = 1'b0;
      cmd           = '0;
      case (state_ff)
         tcsb_pkg::ST_CLEAR: begin
            cmd.sweep_en  = 1'b1;
            cmd.sweep_all = 1'b1;
            if (status.sweep_last) begin
               state_in = tcsb_pkg::ST_IDLE;
            end
         end
         tcsb_pkg::ST_IDLE: begin
            req_tready = status.out_free;
            accept     = req_tvalid & status.out_free;
            if (accept) begin
               if (req_cmd) begin
                  cmd.do_read = 1'b1;
                  state_in    = tcsb_pkg::ST_READ;
               end else begin
                  cmd.do_write = 1'b1;
                  if (status.scroll) begin
                     state_in = tcsb_pkg::ST_SCROLL;
                  end
               end
            end
         end
         tcsb_pkg::ST_READ: begin
            cmd.load_read = 1'b1;
            state_in      = tcsb_pkg::ST_IDLE;
         end
         tcsb_pkg::ST_SCROLL: begin
            cmd.sweep_en = 1'b1;
            if (status.sweep_last) begin
               state_in = tcsb_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = tcsb_pkg::ST_IDLE;
         end
      endcase
   end

`ifndef SYNTHESIS
   // a read always passes through ST_READ, waiting for the store, and then returns to idle
   a_read_one_wait: assert property (@(posedge clock) disable iff (reset)
      cmd.do_read |=> state_ff == tcsb_pkg::ST_READ ##1 state_ff == tcsb_pkg::ST_IDLE)
      else $error("read did not return to idle after one wait cycle");

   // a scrolling write always hands over to the row clear
   a_scroll_clear: assert property (@(posedge clock) disable iff (reset)
      cmd.do_write && status.scroll |=> state_ff == tcsb_pkg::ST_SCROLL)
      else $error("scroll without row clear");

   // nothing taken while sweeping
   a_no_take_sweep: assert property (@(posedge clock) disable iff (reset)
      cmd.sweep_en |-> !(cmd.do_write || cmd.do_read))
      else $error("word taken during a sweep");
`endif

endmodule

>>> hdl/tcsb_datapath.sv
module tcsb_datapath #(
   parameter int COLS = 32,
   parameter int ROWS = 8
) (
   input  logic                   clock,
   input  logic                   reset,
   input  tcsb_pkg::cmd_type      cmd,
   output tcsb_pkg::status_type   status,
   input  logic [7:0]             req_char_code,
   input  logic [2:0]             req_read_row,
   input  logic [4:0]             req_read_col,
   input  logic                   rsp_tready,
   output logic                   rsp_tvalid,
   output logic [7:0]             rsp_cell_char,
   output logic [4:0]             rsp_cursor_col,
   output logic [2:0]             rsp_cursor_row,
   output logic                   rsp_scrolled,
   output logic [15:0]            rsp_write_count
);

   localparam int DEPTH = ROWS * COLS;
   localparam int CW    = (COLS > 1) ? $clog2(COLS) : 1;
   localparam int RW    = (ROWS > 1) ? $clog2(ROWS) : 1;
   localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int LW    = ((RW > tcsb_pkg::ROW_FIELD_W) ? RW : tcsb_pkg::ROW_FIELD_W) + 1;

   // cursor, ring pointer and counter
   logic [CW-1:0]  cur_col_ff, cur_col_in;
   logic [RW-1:0]  cur_row_ff, cur_row_in;
   logic [RW-1:0]  top_ff, top_in;
   logic [15:0]    wcount_ff;
   logic [15:0]    wcount_inc;

   // sweep and read tracking
   logic [AW-1:0]  sweep_cnt_ff;
   logic [AW-1:0]  clr_base_ff;
   logic           rd_ok_ff;
   logic [7:0]     rd_data_ff;

   // output register
   logic           out_valid_ff, out_valid_in;
   logic [7:0]     cell_ff;
   logic [4:0]     ccol_ff;
   logic [2:0]     crow_ff;
   logic           scrolled_ff;
   logic [15:0]    count_ff;

   // text store
   logic [7:0]     text_mem [DEPTH];

   // write path signals
   logic           is_cr, is_lf, is_print;
   logic [CW:0]    col_inc;
   logic           row_adv;
   logic [CW-1:0]  col_step;
   logic           scroll;
   logic [RW:0]    wsum;
   logic [RW-1:0]  wrow;
   logic [AW-1:0]  waddr_char;
   logic [AW-1:0]  sweep_addr;
   logic           we;
   logic [AW-1:0]  waddr;
   logic [7:0]     wdata;
   logic           sweep_last;

   // read path signals
   logic [LW-1:0]  rsum;
   logic [LW-1:0]  rrow;
   logic [CW-1:0]  rcol;
   logic           in_range;
   logic [AW-1:0]  raddr;

   // cursor movement for a write
   always_comb begin
      is_cr    = (req_char_code == tcsb_pkg::CHAR_CR);
      is_lf    = (req_char_code == tcsb_pkg::CHAR_LF);
      is_print = !is_cr && !is_lf;
      col_inc  = {1'b0, cur_col_ff} + (CW+1)'(1);
      row_adv  = 1'b0;
      col_step = cur_col_ff;
      if (is_cr) begin
         col_step = '0;
      end else if (is_lf) begin
         row_adv = 1'b1;
      end else if (col_inc == (CW+1)'(COLS)) begin
         col_step = '0;
         row_adv  = 1'b1;
      end else begin
         col_step = CW'(col_inc);
      end
      scroll = row_adv && (cur_row_ff == RW'(ROWS - 1));
      if (scroll) begin
         cur_col_in = '0;
         cur_row_in = RW'(ROWS - 1);
         top_in     = (top_ff == RW'(ROWS - 1)) ? '0 : top_ff + RW'(1);
      end else begin
         cur_col_in = col_step;
         cur_row_in = cur_row_ff + RW'(row_adv);
         top_in     = top_ff;
      end
   end

   assign wcount_inc = wcount_ff + 16'd1;

   // physical address of the cursor cell
   always_comb begin
      wsum = {1'b0, top_ff} + {1'b0, cur_row_ff};
      if (wsum >= (RW+1)'(ROWS)) begin
         wsum = wsum - (RW+1)'(ROWS);
      end
      wrow       = RW'(wsum);
      waddr_char = AW'(wrow) * AW'(COLS) + AW'(cur_col_ff);
   end

   // physical address of a read
   always_comb begin
      in_range = (int'(req_read_row) < ROWS) && (int'(req_read_col) < COLS);
      rsum     = LW'(top_ff) + LW'(req_read_row);
      rrow     = (rsum >= LW'(ROWS)) ? rsum - LW'(ROWS) : rsum;
      rcol     = CW'(req_read_col);
      raddr    = in_range ? AW'(rrow) * AW'(COLS) + AW'(rcol) : '0;
   end

   // sweep addressing, whole store after reset or one row on scroll
   assign sweep_addr = cmd.sweep_all ? sweep_cnt_ff : clr_base_ff + sweep_cnt_ff;
   assign sweep_last = cmd.sweep_all ? (sweep_cnt_ff == AW'(DEPTH - 1))
                                     : (sweep_cnt_ff == AW'(COLS - 1));

   // write port select
   assign we    = cmd.sweep_en || (cmd.do_write && is_print);
   assign waddr = cmd.sweep_en ? sweep_addr : waddr_char;
   assign wdata = cmd.sweep_en ? tcsb_pkg::CHAR_SPACE : req_char_code;

   // text store, one write and one registered read port
   always_ff @(posedge clock) begin
      if (we) begin
         text_mem[waddr] <= wdata;
      end
      if (cmd.do_read) begin
         rd_data_ff <= text_mem[raddr];
         rd_ok_ff   <= in_range;
      end
   end

   // cursor state and counters
   always_ff @(posedge clock) begin
      if (reset) begin
         cur_col_ff   <= '0;
         cur_row_ff   <= '0;
         top_ff       <= '0;
         wcount_ff    <= '0;
         sweep_cnt_ff <= '0;
      end else begin
         if (cmd.do_write) begin
            cur_col_ff <= cur_col_in;
            cur_row_ff <= cur_row_in;
            top_ff     <= top_in;
            wcount_ff  <= wcount_inc;
         end
         if (cmd.sweep_en) begin
            sweep_cnt_ff <= sweep_last ? '0 : sweep_cnt_ff + AW'(1);
         end
      end
   end

   // base of the row that the scroll frees
   always_ff @(posedge clock) begin
      if (cmd.do_write && scroll) begin
         clr_base_ff <= AW'(top_ff) * AW'(COLS);
      end
   end

   // output register
   assign out_valid_in = cmd.do_write || cmd.load_read || (out_valid_ff && !rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.do_write) begin
         cell_ff     <= '0;
         ccol_ff     <= 5'(cur_col_in);
         crow_ff     <= 3'(cur_row_in);
         scrolled_ff <= scroll;
         count_ff    <= wcount_inc;
      end else if (cmd.load_read) begin
         cell_ff     <= rd_ok_ff ? rd_data_ff : 8'd0;
         ccol_ff     <= 5'(cur_col_ff);
         crow_ff     <= 3'(cur_row_ff);
         scrolled_ff <= 1'b0;
         count_ff    <= wcount_ff;
      end
   end

   assign rsp_tvalid      = out_valid_ff;
   assign rsp_cell_char   = cell_ff;
   assign rsp_cursor_col  = ccol_ff;
   assign rsp_cursor_row  = crow_ff;
   assign rsp_scrolled    = scrolled_ff;
   assign rsp_write_count = count_ff;

   // status to the controller
   assign status.scroll     = scroll;
   assign status.sweep_last = sweep_last;
   assign status.out_free   = !out_valid_ff || rsp_tready;

`ifndef SYNTHESIS
   // a result never overwrites one that is still waiting
   a_no_overrun: assert property (@(posedge clock) disable iff (reset)
      (cmd.do_write || cmd.load_read) |-> (!out_valid_ff || rsp_tready))
      else $error("output register overrun");

   // a scroll leaves the cursor at the start of the last row
   a_scroll_cursor: assert property (@(posedge clock) disable iff (reset)
      cmd.do_write && scroll |=> (cur_col_ff == '0) && (cur_row_ff == RW'(ROWS - 1)))
      else $error("cursor misplaced after scroll");

   // a read leaves the cursor, ring pointer and counter alone
   a_read_stable: assert property (@(posedge clock) disable iff (reset)
      cmd.do_read |=> $stable(cur_col_ff) && $stable(top_ff) && $stable(wcount_ff))
      else $error("read changed console state");
`endif

endmodule

>>> hdl/text_console_scroll_buffer_core.sv
// Character console with a scrolling ROWS x COLS text store.
// req channel: one word per item; req_tuser is the command (0 writes the
// byte in char_code, 1 reads the cell at read_row / read_col, counted from
// the top line). Carriage return and line feed move the cursor, any other
// byte is stored at the cursor. rsp channel: exactly one word per item with
// the cell read (zero for writes and off-screen reads), the cursor after
// the item, the scroll flag and the 16-bit write count.
// A write result is registered on the edge that takes it, a read result on
// the following edge (registered read of the text store). A write that
// scrolls is followed by a clear of its freed row, COLS cells, through the
// single write port before the next word is taken; no word is taken while a
// read waits for the store. Reset: synchronous. Afterwards the store is
// filled with spaces, one cell a cycle, with req_tready low.
// Stall: the result sits in an output register; while rsp_tready is low and
// a result is waiting, req_tready stays low and nothing is lost.
module text_console_scroll_buffer_core #(
   parameter int COLS = 32,
   parameter int ROWS = 8
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // char_code[7:0], read_row[10:8], read_col[15:11]
   input  logic [0:0]  req_tuser,   // cmd[0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata    // cell_char[7:0], cursor_col[12:8], cursor_row[15:13],
                                    // scrolled[16], write_count[32:17], zero[39:33]
);

   tcsb_pkg::cmd_type    cmd;
   tcsb_pkg::status_type status;

   logic [7:0]  cell_char;
   logic [4:0]  cursor_col;
   logic [2:0]  cursor_row;
   logic        scrolled;
   logic [15:0] write_count;

   // sequencing
   tcsb_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_cmd    (req_tuser[0]),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   // store, cursor and output register
   tcsb_datapath #(
      .COLS (COLS),
      .ROWS (ROWS)
   ) u_datapath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .status          (status),
      .req_char_code   (req_tdata[7:0]),
      .req_read_row    (req_tdata[10:8]),
      .req_read_col    (req_tdata[15:11]),
      .rsp_tready      (rsp_tready),
      .rsp_tvalid      (rsp_tvalid),
      .rsp_cell_char   (cell_char),
      .rsp_cursor_col  (cursor_col),
      .rsp_cursor_row  (cursor_row),
      .rsp_scrolled    (scrolled),
      .rsp_write_count (write_count)
   );

   // result word packing
   assign rsp_tdata = {7'd0, write_count, scrolled, cursor_row, cursor_col, cell_char};

endmodule

>>> verif/tb.sv
`timescale 1ns / 1ps

module tb;

   localparam int COLS           = 32;
   localparam int ROWS           = 8;
   localparam int RANDOM_ITEMS   = 700;
   localparam int HOLDOFF_CYCLES = 400;
   localparam int HOLDOFF_AT     = 250;
   localparam int SETTLE_CYCLES  = 3 * COLS;
   localparam int WATCHDOG_LIMIT = 4000;

   // input command codes on req_tuser
   localparam logic CMD_WRITE = 1'b0;
   localparam logic CMD_READ  = 1'b1;

   // receiver readiness patterns
   typedef enum logic [1:0] {
      RX_STEADY,
      RX_BUSY,
      RX_SLUGGISH
   } rx_mode_type;

   // one pending word; hold marks a word that waits for every result first
   typedef struct packed {
      logic       hold;
      logic       cmd;
      logic [4:0] read_col;
      logic [2:0] read_row;
      logic [7:0] char_code;
   } console_item_type;

   // result word in rsp_tdata bit order, lowest field last
   typedef struct packed {
      logic [6:0]  pad;
      logic [15:0] write_count;
      logic        scrolled;
      logic [2:0]  cursor_row;
      logic [4:0]  cursor_col;
      logic [7:0]  cell_char;
   } console_rsp_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [15:0] req_tdata = '0;
   logic [0:0]  req_tuser = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [39:0] rsp_tdata;

   text_console_scroll_buffer_core #(
      .COLS(COLS),
      .ROWS(ROWS)
   ) i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   // console state as predicted
   logic [7:0]  screen_mem [ROWS*COLS];
   int          cur_col;
   int          cur_line;
   int          top_row;
   logic [15:0] write_total;

   console_item_type pending_q[$];
   console_rsp_type  expected_rsp_q[$];
   int               total_items;

   int  outstanding = 0;
   int  items_accepted = 0;
   int  results_seen = 0;
   int  idle_cycles = 0;
   int  fail_count = 0;
   int  writes_seen = 0;
   int  reads_seen = 0;
   int  scrolls_seen = 0;
   bit  in_acc;
   bit  out_acc;

   // advance the predicted console by one word and return its result
   function automatic console_rsp_type console_apply(input logic cmd, input logic [7:0] code,
                                                     input logic [2:0] rrow,
                                                     input logic [4:0] rcol);
      console_rsp_type r;
      int              old_top;
      r = '0;
      if (cmd == CMD_WRITE) begin
         if (code == tcsb_pkg::CHAR_CR) begin
            cur_col = 0;
         end else if (code == tcsb_pkg::CHAR_LF) begin
            cur_line++;
         end else begin
            screen_mem[((top_row + cur_line) % ROWS) * COLS + cur_col] = code;
            cur_col++;
         end
         if (cur_col >= COLS) begin
            cur_line++;
            cur_col = 0;
         end
         // old top line comes back blank at the bottom
         if (cur_line >= ROWS) begin
            old_top = top_row;
            top_row = (top_row + 1) % ROWS;
            for (int c = 0; c < COLS; c++) screen_mem[old_top * COLS + c] = tcsb_pkg::CHAR_SPACE;
            cur_line   = ROWS - 1;
            cur_col    = 0;
            r.scrolled = 1'b1;
         end
         write_total++;
      end else if (int'(rrow) < ROWS && int'(rcol) < COLS) begin
         r.cell_char = screen_mem[((top_row + int'(rrow)) % ROWS) * COLS + int'(rcol)];
      end
      r.cursor_col  = 5'(cur_col);
      r.cursor_row  = 3'(cur_line);
      r.write_count = write_total;
      return r;
   endfunction

   task automatic add_write(input logic [7:0] code);
      console_item_type item;
      item = '{hold: 1'b0, cmd: CMD_WRITE, read_col: 5'($urandom),
               read_row: 3'($urandom), char_code: code};
      pending_q = {pending_q, item};
   endtask

   task automatic add_read(input logic [2:0] rrow, input logic [4:0] rcol);
      console_item_type item;
      item = '{hold: 1'b0, cmd: CMD_READ, read_col: rcol,
               read_row: rrow, char_code: 8'($urandom)};
      pending_q = {pending_q, item};
   endtask

   task automatic report_mismatch(input string field_name, input int want, input int got);
      fail_count++;
      if (fail_count <= 10)
         $display("mismatch at result %0d, %s: expected 0x%0h, got 0x%0h",
                  results_seen, field_name, want, got);
   endtask

   // clock
   initial begin
      forever #4 clock = ~clock;
   end

   // stimulus, reset and end of run
   initial begin
      int choice;
      int len;

      for (int i = 0; i < ROWS * COLS; i++) screen_mem[i] = tcsb_pkg::CHAR_SPACE;
      cur_col     = 0;
      cur_line    = 0;
      top_row     = 0;
      write_total = '0;

      // directed: byte extremes, reads at the corners, line feeds down to a scroll
      add_write(8'h00);
      add_write(8'hFF);
      add_write(8'h07);
      add_read(3'd0, 5'd0);
      add_read(3'd0, 5'd1);
      add_read(3'd0, 5'd2);
      add_write(tcsb_pkg::CHAR_CR);
      add_read(3'd0, 5'd31);
      add_read(3'd7, 5'd0);
      for (int i = 0; i < ROWS - 1; i++) add_write(tcsb_pkg::CHAR_LF);
      add_write(tcsb_pkg::CHAR_LF);
      add_read(3'd7, 5'd31);
      add_read(3'd0, 5'd0);
      add_write(8'h5A);
      add_read(3'd7, 5'd0);
      add_write(tcsb_pkg::CHAR_CR);

      // random: mostly text lines, some reads, stray bytes and line feed storms
      while (pending_q.size() < RANDOM_ITEMS + 20) begin
         choice = $urandom_range(0, 9);
         if (choice <= 5) begin
            len = ($urandom_range(0, 7) == 0) ? $urandom_range(COLS - 2, COLS + 8)
                                              : $urandom_range(0, 24);
            for (int i = 0; i < len; i++) add_write(8'($urandom_range(32, 126)));
            case ($urandom_range(0, 3))
               0: begin
                  add_write(tcsb_pkg::CHAR_CR);
                  add_write(tcsb_pkg::CHAR_LF);
               end
               1: add_write(tcsb_pkg::CHAR_LF);
               2: add_write(tcsb_pkg::CHAR_CR);
               default: ;
            endcase
            if ($urandom_range(0, 1) == 0)
               add_read(3'($urandom_range(0, ROWS - 1)), 5'($urandom_range(0, COLS - 1)));
         end else if (choice <= 7) begin
            repeat ($urandom_range(1, 4)) add_read(3'($urandom), 5'($urandom));
         end else if (choice == 8) begin
            repeat ($urandom_range(1, 6)) add_write(8'($urandom_range(0, 255)));
         end else begin
            repeat ($urandom_range(1, 10)) add_write(tcsb_pkg::CHAR_LF);
         end
      end
      pending_q[350].hold = 1'b1;
      pending_q[$urandom_range(500, pending_q.size() - 1)].hold = 1'b1;
      total_items = pending_q.size();

      repeat (8) @(posedge clock);
      reset <= 1'b0;

      do @(posedge clock);
      while (!(items_accepted == total_items && outstanding == 0));
      repeat (SETTLE_CYCLES) @(posedge clock);

      if (expected_rsp_q.size() != 0) begin
         fail_count++;
         $display("%0d results never arrived", expected_rsp_q.size());
      end
      $display("run covered %0d words: %0d writes, %0d reads, %0d scrolls",
               items_accepted, writes_seen, reads_seen, scrolls_seen);
      $display("%0d results checked, %0d mismatches", results_seen, fail_count);
      if (fail_count == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

   // driver: bursts of words with random gaps, hold words wait for a drained pipe
   int   burst_left = 0;
   int   gap_left = 0;
   logic took;
   console_item_type next_item;

   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         burst_left = $urandom_range(1, 24);
         gap_left   = 0;
      end else begin
         took = req_tvalid && req_tready;
         if (!req_tvalid || took) begin
            if (gap_left > 0) begin
               gap_left--;
               req_tvalid <= 1'b0;
            end else if (pending_q.size() > 0 &&
                         (!pending_q[0].hold || (!took && outstanding == 0))) begin
               next_item = pending_q.pop_front();
               req_tvalid <= 1'b1;
               req_tdata  <= {next_item.read_col, next_item.read_row, next_item.char_code};
               req_tuser  <= next_item.cmd;
               burst_left--;
               if (burst_left <= 0) begin
                  burst_left = $urandom_range(1, 24);
                  gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 9);
               end
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // receiver: windows of steady, busy or sluggish readiness, one long hold-off
   rx_mode_type ready_mode = RX_STEADY;
   int          window_left = 0;
   int          holdoff_left = 0;
   bit          holdoff_done = 1'b0;

   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (!holdoff_done && results_seen >= HOLDOFF_AT) begin
            holdoff_done = 1'b1;
            holdoff_left = HOLDOFF_CYCLES;
         end
         if (holdoff_left > 0) begin
            holdoff_left--;
            rsp_tready <= 1'b0;
         end else begin
            if (window_left == 0) begin
               ready_mode  = rx_mode_type'($urandom_range(0, 2));
               window_left = $urandom_range(8, 80);
            end else begin
               window_left--;
            end
            case (ready_mode)
               RX_STEADY:   rsp_tready <= 1'b1;
               RX_BUSY:     rsp_tready <= ($urandom_range(0, 3) != 0);
               default:     rsp_tready <= ($urandom_range(0, 3) == 0);
            endcase
         end
      end
   end

   // monitor: predict on each accepted input word, check each result word
   console_rsp_type want;
   console_rsp_type got;

   always @(posedge clock) begin
      if (!reset) begin
         in_acc  = req_tvalid && req_tready;
         out_acc = rsp_tvalid && rsp_tready;
         if (in_acc) begin
            want = console_apply(req_tuser[0], req_tdata[7:0], req_tdata[10:8],
                                 req_tdata[15:11]);
            expected_rsp_q = {expected_rsp_q, want};
            if (req_tuser[0] == CMD_WRITE) writes_seen++;
            else reads_seen++;
            if (want.scrolled) scrolls_seen++;
         end
         if (out_acc) begin
            got = rsp_tdata;
            if (expected_rsp_q.size() == 0) begin
               fail_count++;
               if (fail_count <= 10)
                  $display("unexpected result word 0x%010h", rsp_tdata);
            end else begin
               want = expected_rsp_q.pop_front();
               if (got.cell_char != want.cell_char)
                  report_mismatch("cell_char", int'(want.cell_char), int'(got.cell_char));
               if (got.cursor_col != want.cursor_col)
                  report_mismatch("cursor_col", int'(want.cursor_col), int'(got.cursor_col));
               if (got.cursor_row != want.cursor_row)
                  report_mismatch("cursor_row", int'(want.cursor_row), int'(got.cursor_row));
               if (got.scrolled != want.scrolled)
                  report_mismatch("scrolled", int'(want.scrolled), int'(got.scrolled));
               if (got.write_count != want.write_count)
                  report_mismatch("write_count", int'(want.write_count),
                                  int'(got.write_count));
               if (got.pad != want.pad)
                  report_mismatch("pad", int'(want.pad), int'(got.pad));
            end
         end
         outstanding    <= outstanding + int'(in_acc) - int'(out_acc);
         items_accepted <= items_accepted + int'(in_acc);
         results_seen   <= results_seen + int'(out_acc);
      end
   end

   // watchdog on cycles without any accepted word
   always @(posedge clock) begin
      if (!reset) begin
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
            idle_cycles <= 0;
         end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
               $display("timeout after %0d cycles without progress", idle_cycles);
               $display("[FAIL] regression broken");
               $finish;
            end
         end
      end
   end

endmodule

>>> sim.f
hdl/tcsb_pkg.sv
hdl/tcsb_ctrl.sv
hdl/tcsb_datapath.sv
hdl/text_console_scroll_buffer_core.sv
verif/tb.sv
